// ===== rtl/tfn_pkg.sv =====
`timescale 1ns / 1ps
package tfn_pkg;
	localparam int COORD_W = 16;
	localparam int EDGE_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = 31;
	localparam int SUM_W   = 64;
	localparam int LEN_W   = 32;
	localparam int FRAC_W  = 14;
	localparam int NORM_W  = FRAC_W + 2;
	localparam int QUO_W   = FRAC_W + 1;
	localparam int THR_W   = 14;
	localparam int SQ_STAGES  = LEN_W;
	localparam int DIV_STAGES = QUO_W;

	// per-triangle payload carried down the pipe
	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  degen;
	} pay_t;

	typedef struct packed {
		pay_t             pay;
		logic [SUM_W-1:0] sum;
	} sq_in_t;

	typedef struct packed {
		pay_t             pay;
		logic [LEN_W-1:0] len;
	} div_in_t;

	typedef struct packed {
		logic [2:0][QUO_W-1:0] quo;
		logic [2:0]            neg;
		logic                  degen;
	} div_out_t;
endpackage

// ===== rtl/tfn_cross.sv =====
`timescale 1ns / 1ps
module tfn_cross (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [2:0][2:0][tfn_pkg::COORD_W-1:0]  vtx,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output tfn_pkg::sq_in_t                        out_data
);
	localparam int N = 6;

	logic [N-1:0] vld_q;
	logic [N:0]   adv;

	logic signed [5:0][tfn_pkg::EDGE_W-1:0]  edge_s1;
	logic signed [5:0][tfn_pkg::PROD_W-1:0]  prod_s2;
	logic signed [2:0][tfn_pkg::CROSS_W-1:0] cross_s3;
	tfn_pkg::pay_t                           pay_s4;
	tfn_pkg::pay_t                           pay_s5;
	logic [2:0][2*tfn_pkg::MAG_W-1:0]        sq_s5;
	tfn_pkg::sq_in_t                         res_s6;

	logic signed [5:0][tfn_pkg::EDGE_W-1:0]  edge_d;
	logic [2:0][tfn_pkg::CROSS_W-2:0]        mag_full;
	logic [tfn_pkg::CROSS_W-2:0]             mag_or;
	logic [1:0]                              shamt;
	tfn_pkg::pay_t                           pay_d;

	// advance a stage when it is empty or the next one moves
	assign adv[N] = out_ready;
	for (genvar k = 0; k < N; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end
	assign in_ready  = adv[0];
	assign out_valid = vld_q[N-1];
	assign out_data  = res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// edges e = v2 - v1, f = v3 - v1
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			edge_d[c]   = {vtx[1][c][tfn_pkg::COORD_W-1], vtx[1][c]}
				- {vtx[0][c][tfn_pkg::COORD_W-1], vtx[0][c]};
			edge_d[c+3] = {vtx[2][c][tfn_pkg::COORD_W-1], vtx[2][c]}
				- {vtx[0][c][tfn_pkg::COORD_W-1], vtx[0][c]};
		end
	end

	// magnitudes, degenerate flag and shift into 31 bits
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mag_full[c] = cross_s3[c][tfn_pkg::CROSS_W-1]
				? (tfn_pkg::CROSS_W-1)'(-cross_s3[c])
				: (tfn_pkg::CROSS_W-1)'(cross_s3[c]);
		end
		mag_or = mag_full[0] | mag_full[1] | mag_full[2];
		priority if (mag_or[tfn_pkg::MAG_W+2]) shamt = 2'd3;
		else if (mag_or[tfn_pkg::MAG_W+1])     shamt = 2'd2;
		else if (mag_or[tfn_pkg::MAG_W])       shamt = 2'd1;
		else                                   shamt = 2'd0;
		for (int c = 0; c < 3; c++) begin
			pay_d.mag[c] = tfn_pkg::MAG_W'(mag_full[c] >> shamt);
			pay_d.neg[c] = cross_s3[c][tfn_pkg::CROSS_W-1];
		end
		pay_d.degen = (mag_or == '0);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) edge_s1 <= edge_d;
		// products: ey*fz, fy*ez, ez*fx, fz*ex, ex*fy, fx*ey
		if (adv[1]) begin
			prod_s2[0] <= $signed(edge_s1[1]) * $signed(edge_s1[5]);
			prod_s2[1] <= $signed(edge_s1[4]) * $signed(edge_s1[2]);
			prod_s2[2] <= $signed(edge_s1[2]) * $signed(edge_s1[3]);
			prod_s2[3] <= $signed(edge_s1[5]) * $signed(edge_s1[0]);
			prod_s2[4] <= $signed(edge_s1[0]) * $signed(edge_s1[4]);
			prod_s2[5] <= $signed(edge_s1[3]) * $signed(edge_s1[1]);
		end
		if (adv[2]) begin
			for (int c = 0; c < 3; c++) begin
				cross_s3[c] <= {prod_s2[2*c][tfn_pkg::PROD_W-1], prod_s2[2*c]}
					- {prod_s2[2*c+1][tfn_pkg::PROD_W-1], prod_s2[2*c+1]};
			end
		end
		if (adv[3]) pay_s4 <= pay_d;
		if (adv[4]) begin
			pay_s5 <= pay_s4;
			for (int c = 0; c < 3; c++) sq_s5[c] <= pay_s4.mag[c] * pay_s4.mag[c];
		end
		if (adv[5]) begin
			res_s6.pay <= pay_s5;
			res_s6.sum <= tfn_pkg::SUM_W'(sq_s5[0]) + tfn_pkg::SUM_W'(sq_s5[1])
				+ tfn_pkg::SUM_W'(sq_s5[2]);
		end
	end
endmodule

// ===== rtl/tfn_sqrt.sv =====
`timescale 1ns / 1ps
module tfn_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tfn_pkg::sq_in_t   in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output tfn_pkg::div_in_t  out_data
);
	localparam int N     = tfn_pkg::SQ_STAGES;
	localparam int REM_W = tfn_pkg::LEN_W + 2;

	logic [N-1:0] vld_q;
	logic [N:0]   adv;

	tfn_pkg::sq_in_t             pay_s [N];
	logic [REM_W-1:0]            rem_s [N];
	logic [tfn_pkg::LEN_W-1:0]   root_s [N];

	assign adv[N] = out_ready;
	for (genvar k = 0; k < N; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end
	assign in_ready      = adv[0];
	assign out_valid     = vld_q[N-1];
	assign out_data.pay  = pay_s[N-1].pay;
	assign out_data.len  = root_s[N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// one root bit per stage, from the top bit pair down
	for (genvar k = 0; k < N; k++) begin : g_stage
		tfn_pkg::sq_in_t           pay_in;
		logic [REM_W-1:0]          rem_in;
		logic [tfn_pkg::LEN_W-1:0] root_in;
		logic [REM_W+1:0]          rem_sh;
		logic [REM_W+1:0]          trial;
		logic                      take;

		if (k == 0) begin : g_first
			assign pay_in  = in_data;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign pay_in  = pay_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign rem_sh = {rem_in, pay_in.sum[2*(N-1-k)+1 -: 2]};
		assign trial  = {2'b00, root_in, 2'b01};
		assign take   = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				pay_s[k]  <= pay_in;
				rem_s[k]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
				root_s[k] <= {root_in[tfn_pkg::LEN_W-2:0], take};
			end
		end
	end
endmodule

// ===== rtl/tfn_div.sv =====
`timescale 1ns / 1ps
module tfn_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tfn_pkg::div_in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tfn_pkg::div_out_t  out_data
);
	localparam int N     = tfn_pkg::DIV_STAGES;
	localparam int NUM_W = tfn_pkg::MAG_W + tfn_pkg::QUO_W + 1;
	localparam int DEN_W = tfn_pkg::LEN_W + 1;

	logic [N-1:0] vld_q;
	logic [N:0]   adv;

	logic [2:0][NUM_W-1:0]          rem_s [N];
	logic [2:0][tfn_pkg::QUO_W-1:0] quo_s [N];
	logic [DEN_W-1:0]               den_s [N];
	logic [2:0]                     neg_s [N];
	logic                           dg_s [N];

	assign adv[N] = out_ready;
	for (genvar k = 0; k < N; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end
	assign in_ready       = adv[0];
	assign out_valid      = vld_q[N-1];
	assign out_data.quo   = quo_s[N-1];
	assign out_data.neg   = neg_s[N-1];
	assign out_data.degen = dg_s[N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// quotient (mag*2^15 + L) / 2L, one bit per stage, three lanes
	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int SH = N - 1 - k;
		logic [2:0][NUM_W-1:0]          rem_in;
		logic [2:0][tfn_pkg::QUO_W-1:0] quo_in;
		logic [DEN_W-1:0]               den_in;
		logic [2:0]                     neg_in;
		logic                           dg_in;
		logic [NUM_W+1:0]               den_sh;
		logic [2:0][NUM_W-1:0]          rem_nx;
		logic [2:0][tfn_pkg::QUO_W-1:0] quo_nx;

		if (k == 0) begin : g_first
			for (genvar c = 0; c < 3; c++) begin : g_lane
				assign rem_in[c] = NUM_W'({in_data.pay.mag[c], {tfn_pkg::QUO_W{1'b0}}})
					+ NUM_W'(in_data.len);
			end
			assign quo_in = '0;
			assign den_in = {in_data.len, 1'b0};
			assign neg_in = in_data.pay.neg;
			assign dg_in  = in_data.pay.degen;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
			assign neg_in = neg_s[k-1];
			assign dg_in  = dg_s[k-1];
		end

		assign den_sh = (NUM_W+2)'(den_in) << SH;

		always_comb begin
			for (int c = 0; c < 3; c++) begin
				if ((NUM_W+2)'(rem_in[c]) >= den_sh) begin
					rem_nx[c] = NUM_W'((NUM_W+2)'(rem_in[c]) - den_sh);
					quo_nx[c] = quo_in[c] | (tfn_pkg::QUO_W'(1) << SH);
				end else begin
					rem_nx[c] = rem_in[c];
					quo_nx[c] = quo_in[c];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_s[k] <= rem_nx;
				quo_s[k] <= quo_nx;
				den_s[k] <= den_in;
				neg_s[k] <= neg_in;
				dg_s[k]  <= dg_in;
			end
		end
	end
endmodule

// ===== rtl/triangle_face_normal_top.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Content
// s_axis    in   s_tvalid/s_tready  s_tdata: v1 x,y,z, v2 x,y,z, v3 x,y,z
// m_axis    out  m_tvalid/m_tready  m_tdata: norm x,y,z; m_tuser: degenerate
// cfg       in   cfg_we             cfg_wdata: zero_threshold
//
// One triangle per cycle unless stalled; it passes the edge, cross product
// and sum of squares stages, the bit-serial square root pipe (one root bit
// per stage), the divider (one quotient bit per stage) and the output stage.
// Reset clears all valid bits and the threshold; data registers are not reset.
// Each stage advances when empty or when the next stage advances, so bubbles
// collapse and a stalled output holds without losing or repeating requests.
module triangle_face_normal_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,   // v1_x,v1_y,v1_z,v2_x,v2_y,v2_z,v3_x,v3_y,v3_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,   // norm_x, norm_y, norm_z
	output logic         m_tuser,   // degenerate
	input  logic         cfg_we,
	input  logic [13:0]  cfg_wdata  // zero_threshold
);
	logic [tfn_pkg::THR_W-1:0] thr_q;

	logic [2:0][2:0][tfn_pkg::COORD_W-1:0] vtx;
	logic              cr_valid, cr_ready, sq_valid, sq_ready, dv_valid, dv_ready;
	tfn_pkg::sq_in_t   cr_data;
	tfn_pkg::div_in_t  sq_data;
	tfn_pkg::div_out_t dv_data;

	logic [2:0][tfn_pkg::NORM_W-1:0] norm_d;
	logic [2:0][tfn_pkg::NORM_W-1:0] norm_q;
	logic                            dg_q;
	logic                            out_vld_q;

	assign vtx = s_tdata;

	// hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= '0;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	tfn_cross u_cross (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .vtx(vtx),
		.out_valid(cr_valid), .out_ready(cr_ready), .out_data(cr_data)
	);

	tfn_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cr_valid), .in_ready(cr_ready), .in_data(cr_data),
		.out_valid(sq_valid), .out_ready(sq_ready), .out_data(sq_data)
	);

	tfn_div u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sq_valid), .in_ready(sq_ready), .in_data(sq_data),
		.out_valid(dv_valid), .out_ready(dv_ready), .out_data(dv_data)
	);

	// drop small components, apply sign, zero on degenerate
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (dv_data.degen || (dv_data.quo[c] < tfn_pkg::QUO_W'(thr_q)))
				norm_d[c] = '0;
			else if (dv_data.neg[c])
				norm_d[c] = tfn_pkg::NORM_W'(-tfn_pkg::NORM_W'(dv_data.quo[c]));
			else
				norm_d[c] = tfn_pkg::NORM_W'(dv_data.quo[c]);
		end
	end

	assign dv_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (dv_ready) out_vld_q <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (dv_ready) begin
			norm_q <= norm_d;
			dg_q   <= dv_data.degen;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = norm_q;
	assign m_tuser  = dg_q;

`ifndef NO_ASSERTIONS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate request with nonzero normal");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384)
			&& ($signed(m_tdata[15:0]) >= -16'sd16384)
			&& ($signed(m_tdata[31:16]) <= 16'sd16384)
			&& ($signed(m_tdata[31:16]) >= -16'sd16384)
			&& ($signed(m_tdata[47:32]) <= 16'sd16384)
			&& ($signed(m_tdata[47:32]) >= -16'sd16384))
		else $error("normal component out of unit range");

	a_nonzero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata != '0) || (thr_q != '0))
		else $error("zero normal for a non-degenerate triangle");

	a_div_stall: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && !dv_ready |-> m_tvalid && !m_tready)
		else $error("divider stalled while output register free");
`endif
endmodule
